// ===== design/assert_macros.svh =====
// Assertion helpers for the shortest-path block.
// Each check is clocked on the rising edge and idles while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when pre holds, post must hold too
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("implication check failed");

// Next-cycle implication: when pre holds, post must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== design/ssp_pkg.sv =====
package ssp_pkg;

	localparam int VERTEX_W  = 6;
	localparam int WEIGHT_W  = 16;
	localparam int DIST_W    = 32;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_VERTEX   = 2'd2;

	localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 7'd64;

	// Saturation limits of a stored distance
	localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

	// One input transaction: a directed edge
	typedef struct packed {
		logic [VERTEX_W-1:0]        from_vertex;
		logic [VERTEX_W-1:0]        to_vertex;
		logic signed [WEIGHT_W-1:0] weight;
		logic                       last;
	} ssp_in_t;

	// One result transaction
	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic                     unreachable;
		logic                     negative_cycle;
		logic                     edges_dropped;
	} ssp_out_t;

	// Edge as held in the edge memory
	typedef struct packed {
		logic [VERTEX_W-1:0]        from_vertex;
		logic [VERTEX_W-1:0]        to_vertex;
		logic signed [WEIGHT_W-1:0] weight;
	} ssp_edge_t;

	// Phase strobes from the sequencer to the relaxation unit
	typedef struct packed {
		logic init;    // reset marks, seed the start vertex
		logic vert;    // edge word present: read both endpoint distances
		logic add;     // form the candidate distance
		logic cmp;     // compare and write back (or flag a cycle)
		logic check;   // current pass is the negative-cycle pass
		logic rd_end;  // read the distance of the end vertex
	} ssp_ctl_t;

	// Outcome seen by the sequencer once the passes are over
	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic                     unreachable;
		logic                     negative_cycle;
	} ssp_verdict_t;

endpackage

// ===== design/ssp_edge_store.sv =====
module ssp_edge_store #(
	parameter int MAX_EDGES = 256,
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int ECW = $clog2(MAX_EDGES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  ssp_pkg::ssp_edge_t wr_edge,
	input  logic               clear,
	input  logic [EAW-1:0]     rd_addr,
	output ssp_pkg::ssp_edge_t rd_edge,
	output logic [ECW-1:0]     total,
	output logic               dropped
);
	import ssp_pkg::*;

	ssp_edge_t      mem [MAX_EDGES];
	ssp_edge_t      rd_edge_q;
	logic [ECW-1:0] total_q;
	logic           dropped_q;
	logic           full;

	assign full = (total_q == ECW'(MAX_EDGES));

	// Store the edge at the fill position, read back one word per cycle
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem[total_q[EAW-1:0]] <= wr_edge;
		end
		rd_edge_q <= mem[rd_addr];
	end

	// Count stored edges, note any that find the memory full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			dropped_q <= 1'b0;
		end else if (clear) begin
			total_q   <= '0;
			dropped_q <= 1'b0;
		end else if (wr_en) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				total_q <= total_q + ECW'(1);
			end
		end
	end

	assign rd_edge = rd_edge_q;
	assign total   = total_q;
	assign dropped = dropped_q;

endmodule

// ===== design/ssp_relax_unit.sv =====
module ssp_relax_unit #(
	parameter int MAX_VERTICES = 64,
	localparam int VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int CW  = ($clog2(MAX_VERTICES + 1) > 7) ? $clog2(MAX_VERTICES + 1) : 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssp_pkg::ssp_ctl_t                   ctl,
	input  ssp_pkg::ssp_edge_t                  edge_rec,
	input  logic [CW-1:0]                       nv,
	input  logic [ssp_pkg::VERTEX_W-1:0]        start_vertex,
	input  logic [ssp_pkg::VERTEX_W-1:0]        end_vertex,
	output ssp_pkg::ssp_verdict_t               verdict
);
	import ssp_pkg::*;

	logic signed [DIST_W-1:0]   dist_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]    reached_q;
	logic                       cycle_q;

	logic                       ok_q;
	logic                       reach_src_q;
	logic                       reach_dst_q;
	logic [VIW-1:0]             dst_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic signed [DIST_W-1:0]   da_q;
	logic signed [DIST_W-1:0]   db_q;
	logic signed [DIST_W-1:0]   cand_q;

	logic [VIW-1:0]             src_idx;
	logic [VIW-1:0]             dst_idx;
	logic [VIW-1:0]             start_idx;
	logic [VIW-1:0]             end_idx;
	logic [VIW-1:0]             rd_a;
	logic                       src_ok;
	logic                       dst_ok;
	logic                       start_ok;
	logic                       end_ok;
	logic signed [DIST_W:0]     sum;
	logic signed [DIST_W-1:0]   sat;
	logic                       relax;
	logic                       wr_en;
	logic [VIW-1:0]             wr_addr;
	logic signed [DIST_W-1:0]   wr_data;
	logic                       unreach;

	// Decode vertex numbers; only indexes that pass the range check are used
	assign src_idx   = VIW'(edge_rec.from_vertex);
	assign dst_idx   = VIW'(edge_rec.to_vertex);
	assign start_idx = VIW'(start_vertex);
	assign end_idx   = VIW'(end_vertex);
	assign src_ok    = CW'(edge_rec.from_vertex) < nv;
	assign dst_ok    = CW'(edge_rec.to_vertex) < nv;
	assign start_ok  = CW'(start_vertex) < nv;
	assign end_ok    = CW'(end_vertex) < nv;
	assign rd_a      = ctl.rd_end ? end_idx : src_idx;

	// Shared adder with saturation to the distance range
	assign sum = {da_q[DIST_W-1], da_q} + (DIST_W + 1)'(w_q);
	always_comb begin
		if (sum[DIST_W] != sum[DIST_W-1]) begin
			sat = sum[DIST_W] ? DIST_MIN : DIST_MAX;
		end else begin
			sat = sum[DIST_W-1:0];
		end
	end

	// Edge lowers its head's distance (or reaches it for the first time)
	assign relax = ok_q && reach_src_q && (!reach_dst_q || (cand_q < db_q));

	// Single write port: seed at start, relaxed distance otherwise
	assign wr_en   = (ctl.init && start_ok) || (ctl.cmp && relax && !ctl.check);
	assign wr_addr = ctl.init ? start_idx : dst_q;
	assign wr_data = ctl.init ? '0 : cand_q;

	// Distance memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dist_mem[wr_addr] <= wr_data;
		end
		if (ctl.vert || ctl.rd_end) begin
			da_q <= dist_mem[rd_a];
			db_q <= dist_mem[dst_idx];
		end
	end

	// Hold the edge operands through the add and compare phases
	always_ff @(posedge clk) begin
		if (ctl.vert) begin
			dst_q       <= dst_idx;
			w_q         <= edge_rec.weight;
			reach_src_q <= reached_q[src_idx];
			reach_dst_q <= reached_q[dst_idx];
		end
		if (ctl.add) begin
			cand_q <= sat;
		end
	end

	// Reached marks, edge validity and the cycle flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
			cycle_q   <= 1'b0;
			ok_q      <= 1'b0;
		end else begin
			if (ctl.vert) begin
				ok_q <= src_ok && dst_ok;
			end
			if (ctl.init) begin
				reached_q <= '0;
				cycle_q   <= 1'b0;
				if (start_ok) begin
					reached_q[start_idx] <= 1'b1;
				end
			end else if (ctl.cmp && relax) begin
				if (ctl.check) begin
					cycle_q <= 1'b1;
				end else begin
					reached_q[dst_q] <= 1'b1;
				end
			end
		end
	end

	// Outcome; distance comes from the end-vertex read
	assign unreach = !(end_ok && reached_q[end_idx]);
	assign verdict.unreachable    = unreach;
	assign verdict.negative_cycle = cycle_q;
	assign verdict.distance       = (!unreach && !cycle_q) ? da_q : '0;

endmodule

// ===== design/single_source_shortest_path.sv =====
// Channel   Handshake               Payload     Transaction
// in        in_valid / in_stall     in_data     one directed edge, last closes the graph
// out       out_valid / out_stall   out_data    one verdict per graph
// cfg       cfg_write               cfg_data    vertex count, start and end vertex
//
// Edges load at one per cycle into the edge memory while the block is idle.
// After the last edge: a setup state, then P passes over the edge list, where
// P = max(nv - 1, 0) + 1 (relaxation rounds plus the cycle check), then the
// end vertex is read and the result loaded.
// Each edge steps through fetch, read, add and compare in the one shared unit.
// in_stall stays high from the last edge until the result is registered;
// the result register holds under out_stall while new edges load.
// No clearing pass after reset: marks reset at once, distances seed per graph.
`include "assert_macros.svh"

module single_source_shortest_path #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ssp_pkg::ssp_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ssp_pkg::ssp_out_t              out_data,
	input  logic                           cfg_write,
	input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssp_pkg::CFG_W-1:0]      cfg_data
);
	import ssp_pkg::*;

	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int CW  = ($clog2(MAX_VERTICES + 1) > 7) ? $clog2(MAX_VERTICES + 1) : 7;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_VERT  = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_CMP   = 3'd5;
	localparam logic [2:0] S_END   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]          state_q;
	logic [CFG_W-1:0]    vertex_count_q;
	logic [VERTEX_W-1:0] start_vertex_q;
	logic [VERTEX_W-1:0] end_vertex_q;
	logic [ECW-1:0]      k_q;
	logic [CW-1:0]       round_q;
	logic                check_q;
	logic                out_valid_q;
	ssp_out_t            out_data_q;

	logic                in_accept;
	logic                out_free;
	logic [CW-1:0]       vc_ext;
	logic [CW-1:0]       nv;
	logic [CW-1:0]       round_nx;
	ssp_edge_t           wr_edge;
	ssp_edge_t           rd_edge;
	logic [ECW-1:0]      edge_total;
	logic                dropped;
	ssp_ctl_t            ctl;
	ssp_verdict_t        verdict;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Vertex count saturates to the table depth
	assign vc_ext   = CW'(vertex_count_q);
	assign nv       = (vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext;
	assign round_nx = round_q + CW'(1);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RST;
			start_vertex_q <= '0;
			end_vertex_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data;
				REG_START_VERTEX: start_vertex_q <= cfg_data[VERTEX_W-1:0];
				REG_END_VERTEX:   end_vertex_q   <= cfg_data[VERTEX_W-1:0];
				default: ;
			endcase
		end
	end

	assign wr_edge.from_vertex = in_data.from_vertex;
	assign wr_edge.to_vertex   = in_data.to_vertex;
	assign wr_edge.weight      = in_data.weight;

	ssp_edge_store #(
		.MAX_EDGES(MAX_EDGES)
	) u_edge_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_edge (wr_edge),
		.clear   (state_q == S_DONE && out_free),
		.rd_addr (k_q[EAW-1:0]),
		.rd_edge (rd_edge),
		.total   (edge_total),
		.dropped (dropped)
	);

	// Phase strobes for the shared unit
	assign ctl.init   = (state_q == S_INIT);
	assign ctl.vert   = (state_q == S_VERT);
	assign ctl.add    = (state_q == S_ADD);
	assign ctl.cmp    = (state_q == S_CMP);
	assign ctl.check  = check_q;
	assign ctl.rd_end = (state_q == S_END);

	ssp_relax_unit #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_relax (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.edge_rec     (rd_edge),
		.nv           (nv),
		.start_vertex (start_vertex_q),
		.end_vertex   (end_vertex_q),
		.verdict      (verdict)
	);

	// Sequencer: rounds over the edge list, then the cycle-check pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			round_q <= '0;
			check_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && in_data.last) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					k_q     <= '0;
					round_q <= CW'(1);
					check_q <= (nv <= CW'(1));
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (k_q == edge_total) begin
						// end of a pass over the edge list
						k_q <= '0;
						if (check_q) begin
							state_q <= S_END;
						end else if (round_nx >= nv) begin
							check_q <= 1'b1;
						end else begin
							round_q <= round_nx;
						end
					end else begin
						state_q <= S_VERT;
					end
				end
				S_VERT: state_q <= S_ADD;
				S_ADD:  state_q <= S_CMP;
				S_CMP: begin
					k_q     <= k_q + ECW'(1);
					state_q <= S_FETCH;
				end
				S_END: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						check_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register: load when the slot is free, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_data_q.distance       <= verdict.distance;
			out_data_q.unreachable    <= verdict.unreachable;
			out_data_q.negative_cycle <= verdict.negative_cycle;
			out_data_q.edges_dropped  <= dropped;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The last edge of a graph always starts the computation
	`ASSERT_NEXT(a_last_starts, clk, arst_n, in_accept && in_data.last, state_q == S_INIT)
	// The edge index never runs past the stored edges
	`ASSERT_IMPLY(a_k_bound, clk, arst_n, state_q != S_IDLE, k_q <= edge_total)
	// Relaxation rounds stay below the vertex count
	`ASSERT_IMPLY(a_round_bound, clk, arst_n, state_q == S_FETCH && !check_q, round_q < nv)
	// A finished graph yields a waiting result and frees the input
	`ASSERT_NEXT(a_done_out, clk, arst_n, state_q == S_DONE && out_free, out_valid && !in_stall)

endmodule
